@@ design/hcd_pkg.sv @@
// shared types, constants and helper functions for the chunked body decoder
package hcd_pkg;

  // default width of the chunk size and byte counters
  localparam int SIZE_BITS_DEF = 32;

  // configuration register file
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CHUNK_CNT_W = 10;
  localparam logic [CHUNK_CNT_W-1:0] MAX_CHUNKS_RESET = CHUNK_CNT_W'(1000);
  localparam logic REG_MAX_CHUNKS = 1'b0;

  // queue between parser and output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // header match text
  localparam int PAT_LEN = 26;
  localparam int PAT_IDX_W = 5;
  localparam logic [8*PAT_LEN-1:0] TE_TEXT = "Transfer-Encoding: chunked";

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  // one decoded byte on its way to the output stage
  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       done;
  } q_entry_t;

  // push request from the parser into the queue
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  // character of the header match text at a given index, zero past its end
  function automatic logic [7:0] te_char(input logic [PAT_IDX_W-1:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (int'(idx) < PAT_LEN) begin
      c = TE_TEXT[8*(PAT_LEN-1-int'(idx)) +: 8];
    end
    return c;
  endfunction

  // expected byte of the CR LF CR LF end of header
  function automatic logic [7:0] end_char(input logic [1:0] idx);
    return idx[0] ? CHAR_LF : CHAR_CR;
  endfunction

  // hex digit decode: {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'b0;
    if (b >= "0" && b <= "9") begin
      r = {1'b1, 4'(b - "0")};
    end else if (b >= "a" && b <= "f") begin
      r = {1'b1, 4'(b - "a" + 8'd10)};
    end else if (b >= "A" && b <= "F") begin
      r = {1'b1, 4'(b - "A" + 8'd10)};
    end
    return r;
  endfunction

  // whitespace: space, tab, lf, vt, ff, cr
  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SP) || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

endpackage

@@ design/hcd_parse.sv @@
// front part: accepts bytes, tracks header and chunk framing, classifies each byte
module hcd_parse import hcd_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_message_start,
  input  logic [CHUNK_CNT_W-1:0] max_chunks,
  input  logic                   q_full,
  output q_push_t                q_req
);

  typedef enum logic [2:0] {
    M_HEADER,
    M_SIZE,
    M_SIZE_LF,
    M_DATA,
    M_CLOSE,
    M_RAW,
    M_ERROR
  } mode_t;

  mode_t                  mode_r, mode_nxt, mode_c;
  logic [PAT_IDX_W-1:0]   pat_r, pat_nxt, pat_c;
  logic [1:0]             crlf_r, crlf_nxt, crlf_c;
  logic                   chunked_r, chunked_nxt, chunked_c;
  logic                   digit_r, digit_nxt, digit_c;
  logic [SIZE_BITS-1:0]   acc_r, acc_nxt, acc_c;
  logic [SIZE_BITS-1:0]   rem_r, rem_nxt, rem_c;
  logic [CHUNK_CNT_W-1:0] chunk_r, chunk_nxt, chunk_c;
  logic                   in_fire;
  logic [4:0]             hex;
  logic [7:0]             b;

  assign in_ready = ~q_full;
  assign in_fire  = in_valid & in_ready;
  assign b        = in_data_byte;
  assign hex      = hex_val(b);

  // parser next state and byte classification
  always_comb begin
    // message start clears the parser before this byte is looked at
    if (in_message_start) begin
      mode_c    = M_HEADER;
      pat_c     = '0;
      crlf_c    = '0;
      chunked_c = 1'b0;
      digit_c   = 1'b0;
      acc_c     = '0;
      rem_c     = '0;
      chunk_c   = '0;
    end else begin
      mode_c    = mode_r;
      pat_c     = pat_r;
      crlf_c    = crlf_r;
      chunked_c = chunked_r;
      digit_c   = digit_r;
      acc_c     = acc_r;
      rem_c     = rem_r;
      chunk_c   = chunk_r;
    end

    mode_nxt    = mode_c;
    pat_nxt     = pat_c;
    crlf_nxt    = crlf_c;
    chunked_nxt = chunked_c;
    digit_nxt   = digit_c;
    acc_nxt     = acc_c;
    rem_nxt     = rem_c;
    chunk_nxt   = chunk_c;

    q_req.push       = 1'b0;
    q_req.entry.data = b;
    q_req.entry.err  = 1'b0;
    q_req.entry.done = 1'b0;

    case (mode_c)
      M_HEADER: begin
        // look for the transfer-encoding text
        if (!chunked_c) begin
          if (int'(pat_c) < PAT_LEN && b == te_char(pat_c)) begin
            pat_nxt = pat_c + PAT_IDX_W'(1);
          end else begin
            pat_nxt = (b == te_char('0)) ? PAT_IDX_W'(1) : '0;
          end
          if (int'(pat_nxt) >= PAT_LEN) begin
            chunked_nxt = 1'b1;
            pat_nxt     = '0;
          end
        end
        // look for the blank line that ends the header
        if (b == end_char(crlf_c)) begin
          if (crlf_c == 2'd3) begin
            crlf_nxt = '0;
            if (chunked_nxt) begin
              mode_nxt  = M_SIZE;
              digit_nxt = 1'b0;
              acc_nxt   = '0;
            end else begin
              mode_nxt = M_RAW;
            end
          end else begin
            crlf_nxt = crlf_c + 2'd1;
          end
        end else begin
          crlf_nxt = (b == CHAR_CR) ? 2'd1 : 2'd0;
        end
        q_req.push = 1'b1;
      end

      M_SIZE: begin
        if (hex[4]) begin
          // a digit that would overflow the size counts as malformed
          if (acc_c[SIZE_BITS-1 -: 4] != 4'd0) begin
            mode_nxt        = M_ERROR;
            q_req.push      = 1'b1;
            q_req.entry.err = 1'b1;
          end else begin
            acc_nxt   = {acc_c[SIZE_BITS-5:0], hex[3:0]};
            digit_nxt = 1'b1;
          end
        end else if (!digit_c) begin
          if (!is_space(b)) begin
            mode_nxt        = M_ERROR;
            q_req.push      = 1'b1;
            q_req.entry.err = 1'b1;
          end
        end else if (b != CHAR_CR) begin
          mode_nxt        = M_ERROR;
          q_req.push      = 1'b1;
          q_req.entry.err = 1'b1;
        end else begin
          digit_nxt = 1'b0;
          chunk_nxt = chunk_c + CHUNK_CNT_W'(1);
          if (acc_c == '0) begin
            // last chunk: pass the closing sequence
            mode_nxt   = M_CLOSE;
            crlf_nxt   = 2'd3;
            q_req.push = 1'b1;
          end else begin
            rem_nxt  = acc_c;
            mode_nxt = M_SIZE_LF;
          end
        end
      end

      M_SIZE_LF: begin
        mode_nxt = M_DATA;
      end

      M_DATA: begin
        rem_nxt = rem_c - SIZE_BITS'(1);
        if (rem_nxt == '0) begin
          if (chunk_c >= max_chunks) begin
            mode_nxt = M_ERROR;
          end else begin
            mode_nxt  = M_SIZE;
            digit_nxt = 1'b0;
            acc_nxt   = '0;
          end
        end
        q_req.push = 1'b1;
      end

      M_CLOSE: begin
        crlf_nxt   = crlf_c - 2'd1;
        q_req.push = 1'b1;
        if (crlf_nxt == 2'd0) begin
          mode_nxt         = M_RAW;
          q_req.entry.done = 1'b1;
        end
      end

      M_ERROR: begin
        q_req.push      = 1'b1;
        q_req.entry.err = 1'b1;
      end

      default: begin
        q_req.push = 1'b1;
      end
    endcase

    if (!in_fire) begin
      q_req.push = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_HEADER;
      pat_r     <= '0;
      crlf_r    <= '0;
      chunked_r <= 1'b0;
      digit_r   <= 1'b0;
      acc_r     <= '0;
      rem_r     <= '0;
      chunk_r   <= '0;
    end else if (in_fire) begin
      mode_r    <= mode_nxt;
      pat_r     <= pat_nxt;
      crlf_r    <= crlf_nxt;
      chunked_r <= chunked_nxt;
      digit_r   <= digit_nxt;
      acc_r     <= acc_nxt;
      rem_r     <= rem_nxt;
      chunk_r   <= chunk_nxt;
    end
  end

endmodule

@@ design/hcd_queue.sv @@
// short queue of classified bytes between the parser and the output stage
module hcd_queue import hcd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  q_push_t  q_req,
  output logic     q_full,
  input  logic     q_pop,
  output logic     q_valid,
  output q_entry_t q_head
);

  q_entry_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] cnt_r;
  logic                   do_push, do_pop;

  assign q_full  = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_head  = mem_r[rd_ptr_r];
  assign do_push = q_req.push & ~q_full;
  assign do_pop  = q_pop & q_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_req.entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

@@ design/hcd_out.sv @@
// back part: output register that drains the queue onto the result channel
module hcd_out import hcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  q_entry_t   q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_parse_error,
  output logic       out_done_res
);

  logic     out_valid_r;
  q_entry_t out_data_r;

  // load a new request whenever the register is empty or being taken
  assign q_pop = q_valid & (~out_valid_r | out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= q_head;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_data_r.data;
  assign out_parse_error = out_data_r.err;
  assign out_done_res    = out_data_r.done;

endmodule

@@ design/http_chunked_body_decoder.sv @@
// top level of the chunked transfer body decoder
//
// Input channel (in_valid/in_ready): one response byte per request, with
// in_message_start marking the first byte of a new message. Output channel
// (out_valid/out_ready): decoded bytes with parse_error and done_res flags.
// Header bytes always pass; chunk size lines and their CR LF are dropped
// and produce no output request, except the CR LF of the zero size line.
// Throughput: one byte per cycle while the queue is not full.
// A passed byte is written into the queue at the edge that accepts it and
// is then moved into the output register once that register is empty or
// being taken.
// A four-entry queue sits between the parser and the output register; when
// the receiver stalls the queue fills and in_ready drops once it is full.
// Reset (rst_n, synchronous) empties the queue, clears the parser to header
// mode and sets max_chunks to 1000. max_chunks is written over the APB-style
// port at address 0 and should be changed only while the block is idle.
module http_chunked_body_decoder import hcd_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_message_start,
  // decoded output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_parse_error,
  output logic                  out_done_res,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CHUNK_CNT_W-1:0] max_chunks_r;
  q_push_t                q_req;
  q_entry_t               q_head;
  logic                   q_full, q_valid, q_pop;
  logic                   reg_sel;

  // register decode
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1:2] == {(CFG_ADDR_W-2){REG_MAX_CHUNKS}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chunks_r <= MAX_CHUNKS_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      max_chunks_r <= pwdata[CHUNK_CNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? CFG_DATA_W'(max_chunks_r) : '0;

  // front: parser
  hcd_parse #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_message_start(in_message_start),
    .max_chunks      (max_chunks_r),
    .q_full          (q_full),
    .q_req           (q_req)
  );

  // decoupling queue
  hcd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_req  (q_req),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_valid(q_valid),
    .q_head (q_head)
  );

  // back: output register
  hcd_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_parse_error(out_parse_error),
    .out_done_res   (out_done_res)
  );

endmodule

@@ sim/hcd_stream_checker.sv @@
// stream checker for the chunked body decoder: predicts decoded bytes and compares them
module hcd_stream_checker import hcd_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF,
  parameter logic [CFG_ADDR_W-1:0] MAX_CHUNKS_ADDR = '0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_message_start,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_byte,
  input  logic                  out_parse_error,
  input  logic                  out_done_res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    mismatch_cnt,
  output int                    pending_cnt
);

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_SIZE,
    ST_SIZE_LF,
    ST_DATA,
    ST_CLOSE,
    ST_RAW,
    ST_ERROR
  } decode_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       done;
  } decoded_byte_t;

  localparam int TE_LEN = 26;
  localparam logic [8*TE_LEN-1:0] TE_MATCH = "Transfer-Encoding: chunked";

  // parser state mirror
  decode_state_t          state;
  int                     te_idx;
  logic [1:0]             crlf_cnt;
  logic                   te_found;
  logic                   digit_seen;
  logic [SIZE_BITS-1:0]   size_acc;
  logic [SIZE_BITS-1:0]   bytes_left;
  logic [CHUNK_CNT_W-1:0] chunk_cnt;
  logic [CHUNK_CNT_W-1:0] max_chunks;

  decoded_byte_t expected_bytes[$];
  int            fail_cnt = 0;

  function automatic logic [7:0] match_char(input int i);
    return TE_MATCH[8*(TE_LEN-1-i) +: 8];
  endfunction

  task automatic clear_parser();
    state      = ST_HEADER;
    te_idx     = 0;
    crlf_cnt   = '0;
    te_found   = 1'b0;
    digit_seen = 1'b0;
    size_acc   = '0;
    bytes_left = '0;
    chunk_cnt  = '0;
  endtask

  task automatic start_size_line();
    state      = ST_SIZE;
    digit_seen = 1'b0;
    size_acc   = '0;
  endtask

  task automatic expect_byte(input logic [7:0] b, input logic err, input logic done);
    decoded_byte_t e;
    e.data = b;
    e.err  = err;
    e.done = done;
    expected_bytes.push_back(e);
  endtask

  // one accepted byte through the decoder
  task automatic decode_byte(input logic [7:0] b, input logic first);
    logic       hex_ok;
    logic [3:0] nib;
    if (first) clear_parser();
    hex_ok = 1'b1;
    nib    = '0;
    if (b >= "0" && b <= "9") begin
      nib = 4'(b - "0");
    end else if (b >= "a" && b <= "f") begin
      nib = 4'(b - "a" + 8'd10);
    end else if (b >= "A" && b <= "F") begin
      nib = 4'(b - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
    case (state)
      ST_HEADER: begin
        // look for the transfer encoding text, restart on its first char
        if (!te_found) begin
          if (te_idx < TE_LEN && b == match_char(te_idx)) te_idx++;
          else te_idx = (b == match_char(0)) ? 1 : 0;
          if (te_idx >= TE_LEN) begin
            te_found = 1'b1;
            te_idx   = 0;
          end
        end
        // blank line ends the header
        if (b == (crlf_cnt[0] ? CHAR_LF : CHAR_CR)) begin
          if (crlf_cnt == 2'd3) begin
            crlf_cnt = '0;
            if (te_found) start_size_line();
            else state = ST_RAW;
          end else begin
            crlf_cnt++;
          end
        end else begin
          crlf_cnt = (b == CHAR_CR) ? 2'd1 : 2'd0;
        end
        expect_byte(b, 1'b0, 1'b0);
      end
      ST_SIZE: begin
        if (hex_ok) begin
          // a digit that does not fit is a malformed line
          if ((size_acc >> (SIZE_BITS - 4)) != 0) begin
            state = ST_ERROR;
            expect_byte(b, 1'b1, 1'b0);
          end else begin
            size_acc   = (size_acc << 4) | SIZE_BITS'(nib);
            digit_seen = 1'b1;
          end
        end else if (!digit_seen) begin
          if (!(b == " " || (b >= 8'd9 && b <= 8'd13))) begin
            state = ST_ERROR;
            expect_byte(b, 1'b1, 1'b0);
          end
        end else if (b != CHAR_CR) begin
          state = ST_ERROR;
          expect_byte(b, 1'b1, 1'b0);
        end else begin
          digit_seen = 1'b0;
          chunk_cnt  = chunk_cnt + 1'b1;
          if (size_acc == 0) begin
            // last chunk: this cr and three more bytes pass
            state    = ST_CLOSE;
            crlf_cnt = 2'd3;
            expect_byte(b, 1'b0, 1'b0);
          end else begin
            bytes_left = size_acc;
            state      = ST_SIZE_LF;
          end
        end
      end
      ST_SIZE_LF: begin
        state = ST_DATA;
      end
      ST_DATA: begin
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) begin
          if (chunk_cnt >= max_chunks) state = ST_ERROR;
          else start_size_line();
        end
        expect_byte(b, 1'b0, 1'b0);
      end
      ST_CLOSE: begin
        crlf_cnt = crlf_cnt - 1'b1;
        if (crlf_cnt == 0) begin
          state = ST_RAW;
          expect_byte(b, 1'b0, 1'b1);
        end else begin
          expect_byte(b, 1'b0, 1'b0);
        end
      end
      ST_ERROR: begin
        expect_byte(b, 1'b1, 1'b0);
      end
      default: begin
        expect_byte(b, 1'b0, 1'b0);
      end
    endcase
  endtask

  // compare output requests, track config writes, predict input requests
  always @(posedge clk) begin
    decoded_byte_t e;
    if (!rst_n) begin
      max_chunks = MAX_CHUNKS_RESET;
      clear_parser();
      expected_bytes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: output request with nothing expected: byte %02h error %0b done %0b",
                   $time, out_byte, out_parse_error, out_done_res);
          fail_cnt++;
        end else begin
          e = expected_bytes.pop_front();
          if (e.data !== out_byte) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, e.data, out_byte);
            fail_cnt++;
          end
          if (e.err !== out_parse_error) begin
            $display("%0t: out_parse_error expected %0b actual %0b (byte %02h)",
                     $time, e.err, out_parse_error, e.data);
            fail_cnt++;
          end
          if (e.done !== out_done_res) begin
            $display("%0t: out_done_res expected %0b actual %0b (byte %02h)",
                     $time, e.done, out_done_res, e.data);
            fail_cnt++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == MAX_CHUNKS_ADDR) begin
        max_chunks = pwdata[CHUNK_CNT_W-1:0];
      end
      if (in_valid && in_ready) decode_byte(in_data_byte, in_message_start);
    end
    mismatch_cnt <= fail_cnt;
    pending_cnt  <= expected_bytes.size();
  end

endmodule

@@ sim/tb_top.sv @@
// testbench top for the chunked body decoder: clock, reset, stimulus and verdict
module tb_top;
  import hcd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_PAD = 6;
  localparam int PHASE_ITEMS = 30;
  localparam logic [CFG_ADDR_W-1:0] MAX_CHUNKS_ADDR =
    CFG_ADDR_W'(4 * int'(REG_MAX_CHUNKS));
  localparam string TE_LINE = "Transfer-Encoding: chunked";

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_data_byte;
  logic                  in_message_start;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_byte;
  logic                  out_parse_error;
  logic                  out_done_res;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int   mismatch_cnt;
  int   pending_cnt;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   items_sent = 0;
  int   cycle_cnt = 0;
  logic hold_req = 1'b0;

  logic [7:0] msg_bytes[$];
  string header_fillers[5] = '{"Host: h", "Transfer-Encoding: chunke",
                               "TTransfer-Encoding: gzip", "Via:\015", "Connection: close"};
  string te_lines[3] = '{TE_LINE, "Transfer-Transfer-Encoding: chunked",
                         "X-Transfer-Encoding: chunked"};
  logic [7:0] ws_chars[6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
  int limits[4] = '{1023, 2, 1, 3};
  int idles[4]  = '{0, 57, 0, 7};
  int stalls[4] = '{0, 0, 57, 7};

  http_chunked_body_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_message_start (in_message_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_parse_error  (out_parse_error),
    .out_done_res     (out_done_res),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  hcd_stream_checker #(
    .MAX_CHUNKS_ADDR (MAX_CHUNKS_ADDR)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_message_start (in_message_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_parse_error  (out_parse_error),
    .out_done_res     (out_done_res),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatch_cnt     (mismatch_cnt),
    .pending_cnt      (pending_cnt)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // one input request, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_message_start <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == 0);
    msg_bytes.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endtask

  task automatic add_line(input string s);
    add_text(s);
    msg_bytes.push_back(CHAR_CR);
    msg_bytes.push_back(CHAR_LF);
  endtask

  task automatic add_random(input int n);
    repeat (n) msg_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_ws(input int n);
    repeat (n) msg_bytes.push_back(ws_chars[$urandom_range(5)]);
  endtask

  function automatic logic [7:0] hex_char(input int nib);
    if (nib < 10) return 8'("0" + nib);
    return 8'(($urandom_range(1) ? "A" : "a") + nib - 10);
  endfunction

  // hex size in mixed case, sometimes with leading zeros
  task automatic add_size(input int unsigned n);
    int nd;
    nd = 1;
    while (nd < 8 && (n >> (4 * nd)) != 0) nd++;
    if ($urandom_range(3) == 0) nd += $urandom_range(1, 3);
    for (int i = nd - 1; i >= 0; i--) msg_bytes.push_back(hex_char((n >> (4 * i)) & 15));
  endtask

  // byte that breaks a size line, before or after its first digit
  function automatic logic [7:0] junk_byte(input bit after_digit);
    logic [7:0] b;
    logic [4:0] h;
    do begin
      b = 8'($urandom_range(255));
      h = hex_val(b);
    end while (h[4] || (after_digit ? (b == CHAR_CR) : is_space(b)));
    return b;
  endfunction

  // mostly well-formed chunked messages, some plain, broken, cut short or noise
  task automatic build_random_message();
    int kind;
    int nfill;
    int te_at;
    int sz;
    int keep;
    kind = $urandom_range(99);
    if (kind < 6) begin
      add_random($urandom_range(1, 12));
      return;
    end
    nfill = $urandom_range(2);
    te_at = (kind < 16) ? -1 : $urandom_range(nfill);
    for (int i = 0; i <= nfill; i++) begin
      if (i == te_at) add_line(te_lines[$urandom_range(2)]);
      else add_line(header_fillers[$urandom_range(4)]);
    end
    add_line("");
    if (te_at < 0) begin
      add_random($urandom_range(1, 10));
      return;
    end
    repeat ($urandom_range(3)) begin
      add_ws($urandom_range(2));
      sz = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      add_size(sz);
      msg_bytes.push_back(CHAR_CR);
      msg_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : CHAR_LF);
      add_random(sz);
      add_line("");
    end
    if (kind < 28) begin
      // malformed size line, then raw bytes
      case ($urandom_range(2))
        0: msg_bytes.push_back(junk_byte(1'b0));
        1: begin
          add_size($urandom_range(1, 255));
          msg_bytes.push_back(junk_byte(1'b1));
        end
        default: begin
          msg_bytes.push_back(hex_char($urandom_range(1, 15)));
          repeat (8) msg_bytes.push_back(hex_char($urandom_range(15)));
        end
      endcase
      add_random($urandom_range(4));
    end else begin
      // zero size and the closing bytes, then raw bytes after done
      add_ws($urandom_range(1));
      add_size(0);
      msg_bytes.push_back(CHAR_CR);
      if ($urandom_range(9) == 0) begin
        add_random(3);
      end else begin
        msg_bytes.push_back(CHAR_LF);
        add_line("");
      end
      add_random($urandom_range(3));
    end
    if ($urandom_range(19) == 0) begin
      keep = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
    end
  endtask

  // stop sending and let every expected byte arrive
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_max_chunks(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_CHUNKS_ADDR;
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stimulus
  initial begin
    int phase_start;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_data_byte     <= '0;
    in_message_start <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every whitespace before a size, extreme data bytes, zero size close, raw after done
    add_line(TE_LINE);
    add_line("");
    add_text(" \t\013\014\015\012");
    add_line("2");
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'hff);
    add_line("");
    add_line("0");
    add_line("");
    msg_bytes.push_back(8'h80);
    send_message();
    // size overflow on the ninth digit
    add_line(TE_LINE);
    add_line("");
    add_text("1fffFFFFF");
    msg_bytes.push_back(8'h7f);
    send_message();
    // header without chunked encoding: body passes raw
    add_line("Host: h");
    add_line("");
    add_line("7");
    send_message();
    // junk before the first digit, then junk after a digit
    add_line(TE_LINE);
    add_line("");
    add_text("Z1");
    send_message();
    add_line(TE_LINE);
    add_line("");
    add_text("3;x");
    send_message();

    // chunk limit of one
    wait_drained();
    write_max_chunks(1);
    add_line(TE_LINE);
    add_line("");
    add_line("1");
    add_line("A");
    add_line("1");
    add_text("B");
    send_message();

    // random phases, each with its own limit and idling mix
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      write_max_chunks(limits[p]);
      idle_pct  = idles[p];
      stall_pct = stalls[p];
      if (p == 0) hold_req <= 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        build_random_message();
        send_message();
      end
    end

    wait_drained();
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
